/* design/rgb_led_effect_controller_unit_macros.svh */
// Assertion macros for the RGB LED effect controller.
// Included by the top level; no other dependencies.
`ifndef RGB_LED_EFFECT_CONTROLLER_UNIT_MACROS_SVH
`define RGB_LED_EFFECT_CONTROLLER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RGBLED_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbled assertion failed");
`define RGBLED_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbled assertion failed");
`else
`define RGBLED_ASSERT_SAME(lbl, ante, cons)
`define RGBLED_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/rgbled_pkg.sv */
// Shared types and constants of the RGB LED effect controller.
// No dependencies; used by every module of the block.
package rgbled_pkg;

    localparam int CH_W    = 8;
    localparam int DUTY_W  = 10;
    localparam int HUE_W   = 13;
    localparam int PCT_W   = 15;
    localparam int CMD_W   = 3;
    localparam int MODE_W  = 2;
    localparam int PER_W   = 10;
    localparam int NUM_W   = 30;
    localparam int DEN_W   = 15;
    localparam int K_W     = 11;
    localparam int RY_W    = 23;
    localparam int RM_W    = 24;
    localparam int RP_W    = 47;

    localparam logic [HUE_W-1:0] HUE_FULL  = 13'd5760;
    localparam logic [HUE_W-1:0] HUE_SIXTY = 13'd960;
    localparam logic [HUE_W-1:0] RUN_STEP  = 13'd8;
    localparam logic [HUE_W-1:0] RUN_WRAP  = 13'd5744;
    localparam logic [PCT_W-1:0] PCT_FULL  = 15'd25600;
    localparam logic [PCT_W-1:0] PCT_HALF  = 15'd12800;
    localparam logic [PCT_W-1:0] PCT_ONE   = 15'd256;
    localparam logic [PCT_W-1:0] CH_MAX    = 15'd255;

    // Reciprocals for division by 100, 15 and 255, rounded up, scaled by 2^29, 2^23 and 2^31.
    localparam logic [RM_W-1:0] RCP_100 = 24'd5368710;
    localparam logic [RM_W-1:0] RCP_15  = 24'd559241;
    localparam logic [RM_W-1:0] RCP_255 = 24'd8421505;

    localparam logic [PER_W-1:0] RUN_PERIOD_RST   = 10'd50;
    localparam logic [PER_W-1:0] PULSE_PERIOD_RST = 10'd30;

    localparam logic [CMD_W-1:0] CMD_SET_RGB   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_HSV   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_MODE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_POWER = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd4;

    localparam logic [MODE_W-1:0] MODE_SOLID = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PULSE = 2'd2;

    localparam logic [0:0] REG_RUN_PERIOD   = 1'b0;
    localparam logic [0:0] REG_PULSE_PERIOD = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_SET_RGB,
        OP_SET_HSV,
        OP_SET_MODE,
        OP_SET_POWER,
        OP_TICK,
        OP_CLR_TICK_RUN,
        OP_CLR_TICK,
        OP_RUN_STEP,
        OP_PULSE_STEP,
        OP_MUL_VS,
        OP_DIV_C,
        OP_TAKE_C,
        OP_MUL_X,
        OP_DIV_X,
        OP_TAKE_X,
        OP_MUL_CH,
        OP_DIV_CH,
        OP_TAKE_CH,
        OP_DIV_HUE,
        OP_TAKE_HUE,
        OP_DIV_SAT,
        OP_TAKE_SAT,
        OP_DIV_VAL,
        OP_TAKE_VAL,
        OP_EMIT_STORED,
        OP_EMIT_RES,
        OP_STORE_EMIT_RES,
        OP_EMIT_ZERO
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [MODE_W-1:0] mode_sel;
        logic              power_on;
        logic              light_on;
        logic [MODE_W-1:0] mode;
        logic              tick_hit;
        logic              div_busy;
        logic              ch_last;
        logic              out_free;
    } dp_stat_t;

endpackage

/* design/rgbled_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on rgbled_pkg for its widths.
module rgbled_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rgbled_pkg::NUM_W-1:0]  dividend,
    input  logic [rgbled_pkg::DEN_W-1:0]  divisor,
    output logic                          busy,
    output logic [rgbled_pkg::NUM_W-1:0]  quotient
);
    localparam int NW    = rgbled_pkg::NUM_W;
    localparam int DW    = rgbled_pkg::DEN_W;
    localparam int CNT_W = $clog2(NW);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW:0]      rem_reg, rem_next;
    logic [NW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [DW:0]      rem_sh;
    logic [DW+1:0]    diff;

    always_comb
    begin
        rem_sh    = {rem_reg[DW-1:0], quo_reg[NW-1]};
        diff      = {1'b0, rem_sh} - {2'b00, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NW - 1);
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DW+1])
            begin
                rem_next = diff[DW:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule

/* design/rgbled_dp.sv */
// Datapath: colour state, effect state, shared multiplier, divider and output register.
// Depends on rgbled_pkg and rgbled_div; driven by rgbled_ctrl.
module rgbled_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rgbled_pkg::dp_cmd_t                cmd,
    output rgbled_pkg::dp_stat_t               stat,
    input  logic                               in_accept,
    input  logic [rgbled_pkg::CMD_W-1:0]       command,
    input  logic [rgbled_pkg::CH_W-1:0]        red_in,
    input  logic [rgbled_pkg::CH_W-1:0]        green_in,
    input  logic [rgbled_pkg::CH_W-1:0]        blue_in,
    input  logic [rgbled_pkg::HUE_W-1:0]       hue_in,
    input  logic [rgbled_pkg::PCT_W-1:0]       sat_in,
    input  logic [rgbled_pkg::PCT_W-1:0]       val_in,
    input  logic [rgbled_pkg::MODE_W-1:0]      mode_sel,
    input  logic                               power_on,
    input  logic [rgbled_pkg::PER_W-1:0]       run_period,
    input  logic [rgbled_pkg::PER_W-1:0]       pulse_period,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rgbled_pkg::DUTY_W-1:0]      red_duty,
    output logic [rgbled_pkg::DUTY_W-1:0]      green_duty,
    output logic [rgbled_pkg::DUTY_W-1:0]      blue_duty
);
    localparam int CW = rgbled_pkg::CH_W;
    localparam int HW = rgbled_pkg::HUE_W;
    localparam int PW = rgbled_pkg::PCT_W;
    localparam int NW = rgbled_pkg::NUM_W;
    localparam int DW = rgbled_pkg::DEN_W;
    localparam int KW = rgbled_pkg::K_W;
    localparam int TW = rgbled_pkg::PER_W;
    localparam int YW = rgbled_pkg::RY_W;
    localparam int MW = rgbled_pkg::RM_W;
    localparam int QW = rgbled_pkg::RP_W;

    rgbled_pkg::dp_op_t op;

    logic [rgbled_pkg::CMD_W-1:0]  cmd_l_reg;
    logic [CW-1:0]                 red_l_reg, green_l_reg, blue_l_reg;
    logic [HW-1:0]                 hue_l_reg;
    logic [PW-1:0]                 sat_l_reg, val_l_reg;
    logic [rgbled_pkg::MODE_W-1:0] mode_l_reg;
    logic                          power_l_reg;

    logic [CW-1:0]                 st_r_reg, st_g_reg, st_b_reg;
    logic [rgbled_pkg::MODE_W-1:0] mode_reg;
    logic                          light_reg;
    logic [HW-1:0]                 run_hue_reg, p_hue_reg;
    logic [PW-1:0]                 p_sat_reg, p_val_reg;
    logic                          falling_reg;
    logic [TW-1:0]                 tick_reg;

    logic [HW-1:0]  h_reg;
    logic [PW-1:0]  s_reg, v_reg, c_reg, x_reg;
    logic [NW-1:0]  prod_reg;
    logic [PW-1:0]  cq_reg;
    logic [1:0]     idx_reg;
    logic [CW-1:0]  res_r_reg, res_g_reg, res_b_reg;
    logic           ovalid_reg;
    logic [rgbled_pkg::DUTY_W-1:0] od_r_reg, od_g_reg, od_b_reg;

    logic [2:0]     sector;
    logic [HW-1:0]  base, h_off;
    logic [9:0]     frac, t_w;
    logic [PW-1:0]  m_w, cr, cg, cb, ch_w, ch_sum;
    logic [PW-1:0]  mul_a, mul_b;
    logic [NW-1:0]  prod_w;
    logic [CW-1:0]  mx, mn, d_w;
    logic [KW-1:0]  k_w;
    logic [NW-1:0]  num_w;
    logic           div_start, div_busy;
    logic [NW-1:0]  div_n, quo;
    logic [DW-1:0]  div_d;
    logic [YW-1:0]  rcp_y;
    logic [MW-1:0]  rcp_m;
    logic [QW-1:0]  rcp_p;
    logic [PW-1:0]  rcp_q;
    logic [TW-1:0]  tick_inc, period;
    logic [HW-1:0]  hue_norm, run_next;
    logic [PW-1:0]  sat_clip, val_clip, pv_step, pv_next;
    logic           pf_next;

    assign op = cmd.op;

    always_comb
    begin
        priority if (h_reg >= 13'd4800) sector = 3'd5;
        else if (h_reg >= 13'd3840)     sector = 3'd4;
        else if (h_reg >= 13'd2880)     sector = 3'd3;
        else if (h_reg >= 13'd1920)     sector = 3'd2;
        else if (h_reg >= 13'd960)      sector = 3'd1;
        else                            sector = 3'd0;
        unique case (sector)
            3'd0:    base = 13'd0;
            3'd1:    base = 13'd960;
            3'd2:    base = 13'd1920;
            3'd3:    base = 13'd2880;
            3'd4:    base = 13'd3840;
            default: base = 13'd4800;
        endcase
        h_off = h_reg - base;
        frac  = h_off[9:0];
        t_w   = sector[0] ? (rgbled_pkg::HUE_SIXTY[9:0] - frac) : frac;
        m_w   = v_reg - c_reg;
        unique case (sector)
            3'd0:    begin cr = c_reg; cg = x_reg; cb = '0;    end
            3'd1:    begin cr = x_reg; cg = c_reg; cb = '0;    end
            3'd2:    begin cr = '0;    cg = c_reg; cb = x_reg; end
            3'd3:    begin cr = '0;    cg = x_reg; cb = c_reg; end
            3'd4:    begin cr = x_reg; cg = '0;    cb = c_reg; end
            default: begin cr = c_reg; cg = '0;    cb = x_reg; end
        endcase
        unique case (idx_reg)
            2'd0:    ch_w = cr;
            2'd1:    ch_w = cg;
            default: ch_w = cb;
        endcase
        ch_sum = ch_w + m_w;
    end

    always_comb
    begin
        unique case (op)
            rgbled_pkg::OP_MUL_X:
            begin
                mul_a = c_reg;
                mul_b = PW'(t_w);
            end
            rgbled_pkg::OP_MUL_CH:
            begin
                mul_a = ch_sum;
                mul_b = rgbled_pkg::CH_MAX;
            end
            default:
            begin
                mul_a = v_reg;
                mul_b = s_reg;
            end
        endcase
        prod_w = NW'(mul_a) * NW'(mul_b);
    end

    always_comb
    begin
        mx = st_r_reg;
        mn = st_r_reg;
        if (st_g_reg > mx) mx = st_g_reg;
        if (st_b_reg > mx) mx = st_b_reg;
        if (st_g_reg < mn) mn = st_g_reg;
        if (st_b_reg < mn) mn = st_b_reg;
        d_w = mx - mn;
        priority if (d_w == '0)
            k_w = '0;
        else if (mx == st_r_reg)
        begin
            if (st_g_reg >= st_b_reg)
                k_w = KW'(st_g_reg) - KW'(st_b_reg);
            else
                k_w = KW'(d_w) * KW'(6) - (KW'(st_b_reg) - KW'(st_g_reg));
        end
        else if (mx == st_g_reg)
            k_w = KW'(d_w) * KW'(2) + KW'(st_b_reg) - KW'(st_r_reg);
        else
            k_w = KW'(d_w) * KW'(4) + KW'(st_r_reg) - KW'(st_g_reg);
        num_w = NW'(k_w) * NW'(rgbled_pkg::HUE_SIXTY);
    end

    always_comb
    begin
        div_start = 1'b1;
        div_n     = num_w;
        div_d     = DW'(1);
        unique case (op)
            rgbled_pkg::OP_DIV_HUE:
            begin
                div_n = num_w;
                div_d = (d_w == '0) ? DW'(1) : DW'(d_w);
            end
            rgbled_pkg::OP_DIV_SAT:
            begin
                div_n = NW'(d_w) * NW'(rgbled_pkg::PCT_FULL);
                div_d = DW'(mx);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Division by 25600 is a shift by 8 and a division by 100, by 960 a shift by 6 and a
    // division by 15; the constant divisions are reciprocal multiplications.
    always_comb
    begin
        unique case (op)
            rgbled_pkg::OP_DIV_X:
            begin
                rcp_y = prod_reg[28:6];
                rcp_m = rgbled_pkg::RCP_15;
            end
            rgbled_pkg::OP_DIV_VAL:
            begin
                rcp_y = YW'(mx) * YW'(rgbled_pkg::PCT_FULL);
                rcp_m = rgbled_pkg::RCP_255;
            end
            default:
            begin
                rcp_y = {1'b0, prod_reg[NW-1:8]};
                rcp_m = rgbled_pkg::RCP_100;
            end
        endcase
        rcp_p = QW'(rcp_y) * QW'(rcp_m);
        unique case (op)
            rgbled_pkg::OP_DIV_X:   rcp_q = rcp_p[37:23];
            rgbled_pkg::OP_DIV_VAL: rcp_q = rcp_p[45:31];
            default:                rcp_q = rcp_p[43:29];
        endcase
    end

    rgbled_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .busy     (div_busy),
        .quotient (quo)
    );

    always_comb
    begin
        tick_inc = tick_reg + TW'(1);
        period   = (mode_reg == rgbled_pkg::MODE_RUN) ? run_period : pulse_period;
        hue_norm = (hue_l_reg >= rgbled_pkg::HUE_FULL) ? hue_l_reg - rgbled_pkg::HUE_FULL
                                                       : hue_l_reg;
        sat_clip = (sat_l_reg > rgbled_pkg::PCT_FULL) ? rgbled_pkg::PCT_FULL : sat_l_reg;
        val_clip = (val_l_reg > rgbled_pkg::PCT_FULL) ? rgbled_pkg::PCT_FULL : val_l_reg;
        run_next = run_hue_reg + rgbled_pkg::RUN_STEP;
        if (run_next > rgbled_pkg::RUN_WRAP)
            run_next = '0;
        if (falling_reg)
            pv_step = (p_val_reg >= rgbled_pkg::PCT_ONE) ? p_val_reg - rgbled_pkg::PCT_ONE : '0;
        else
            pv_step = p_val_reg + rgbled_pkg::PCT_ONE;
        pv_next = pv_step;
        pf_next = falling_reg;
        if (pv_step < rgbled_pkg::PCT_HALF)
            pf_next = ~falling_reg;
        if (pv_step > rgbled_pkg::PCT_FULL)
        begin
            pf_next = ~falling_reg;
            pv_next = rgbled_pkg::PCT_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_r_reg    <= '0;
            st_g_reg    <= '0;
            st_b_reg    <= '0;
            mode_reg    <= rgbled_pkg::MODE_SOLID;
            light_reg   <= 1'b0;
            run_hue_reg <= '0;
            p_hue_reg   <= '0;
            p_sat_reg   <= '0;
            p_val_reg   <= '0;
            falling_reg <= 1'b1;
            tick_reg    <= '0;
            ovalid_reg  <= 1'b0;
            cmd_l_reg   <= '0;
        end
        else
        begin
            if (in_accept)
                cmd_l_reg <= command;
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            unique case (op)
                rgbled_pkg::OP_SET_RGB:
                begin
                    st_r_reg <= red_l_reg;
                    st_g_reg <= green_l_reg;
                    st_b_reg <= blue_l_reg;
                end
                rgbled_pkg::OP_SET_HSV:
                begin
                    p_hue_reg <= hue_norm;
                    p_sat_reg <= sat_clip;
                    p_val_reg <= val_clip;
                end
                rgbled_pkg::OP_SET_MODE:   mode_reg  <= mode_l_reg;
                rgbled_pkg::OP_SET_POWER:  light_reg <= power_l_reg;
                rgbled_pkg::OP_TICK:       tick_reg  <= (tick_inc >= period) ? '0 : tick_inc;
                rgbled_pkg::OP_CLR_TICK_RUN:
                begin
                    tick_reg    <= '0;
                    run_hue_reg <= '0;
                end
                rgbled_pkg::OP_CLR_TICK:   tick_reg    <= '0;
                rgbled_pkg::OP_RUN_STEP:   run_hue_reg <= run_next;
                rgbled_pkg::OP_PULSE_STEP:
                begin
                    p_val_reg   <= pv_next;
                    falling_reg <= pf_next;
                end
                rgbled_pkg::OP_TAKE_HUE:   p_hue_reg <= quo[HW-1:0];
                rgbled_pkg::OP_TAKE_SAT:   p_sat_reg <= (mx == '0) ? '0 : quo[PW-1:0];
                rgbled_pkg::OP_TAKE_VAL:   p_val_reg <= cq_reg;
                rgbled_pkg::OP_STORE_EMIT_RES:
                begin
                    st_r_reg   <= res_r_reg;
                    st_g_reg   <= res_g_reg;
                    st_b_reg   <= res_b_reg;
                    ovalid_reg <= 1'b1;
                end
                rgbled_pkg::OP_EMIT_STORED, rgbled_pkg::OP_EMIT_RES,
                rgbled_pkg::OP_EMIT_ZERO:
                    ovalid_reg <= 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            red_l_reg   <= red_in;
            green_l_reg <= green_in;
            blue_l_reg  <= blue_in;
            hue_l_reg   <= hue_in;
            sat_l_reg   <= sat_in;
            val_l_reg   <= val_in;
            mode_l_reg  <= mode_sel;
            power_l_reg <= power_on;
        end
        unique case (op)
            rgbled_pkg::OP_SET_HSV:
            begin
                h_reg <= hue_norm;
                s_reg <= sat_clip;
                v_reg <= val_clip;
            end
            rgbled_pkg::OP_RUN_STEP:
            begin
                h_reg <= run_next;
                s_reg <= rgbled_pkg::PCT_FULL;
                v_reg <= rgbled_pkg::PCT_FULL;
            end
            rgbled_pkg::OP_PULSE_STEP:
            begin
                h_reg <= p_hue_reg;
                s_reg <= p_sat_reg;
                v_reg <= pv_next;
            end
            rgbled_pkg::OP_MUL_VS:
            begin
                prod_reg <= prod_w;
                idx_reg  <= 2'd0;
            end
            rgbled_pkg::OP_MUL_X, rgbled_pkg::OP_MUL_CH:
                prod_reg <= prod_w;
            rgbled_pkg::OP_DIV_C, rgbled_pkg::OP_DIV_X, rgbled_pkg::OP_DIV_CH,
            rgbled_pkg::OP_DIV_VAL:
                cq_reg <= rcp_q;
            rgbled_pkg::OP_TAKE_C: c_reg <= cq_reg;
            rgbled_pkg::OP_TAKE_X: x_reg <= cq_reg;
            rgbled_pkg::OP_TAKE_CH:
            begin
                unique case (idx_reg)
                    2'd0:    res_r_reg <= cq_reg[CW-1:0];
                    2'd1:    res_g_reg <= cq_reg[CW-1:0];
                    default: res_b_reg <= cq_reg[CW-1:0];
                endcase
                idx_reg <= idx_reg + 2'd1;
            end
            rgbled_pkg::OP_EMIT_STORED:
            begin
                od_r_reg <= {st_r_reg, 2'b00};
                od_g_reg <= {st_g_reg, 2'b00};
                od_b_reg <= {st_b_reg, 2'b00};
            end
            rgbled_pkg::OP_EMIT_RES, rgbled_pkg::OP_STORE_EMIT_RES:
            begin
                od_r_reg <= {res_r_reg, 2'b00};
                od_g_reg <= {res_g_reg, 2'b00};
                od_b_reg <= {res_b_reg, 2'b00};
            end
            rgbled_pkg::OP_EMIT_ZERO:
            begin
                od_r_reg <= '0;
                od_g_reg <= '0;
                od_b_reg <= '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat.cmd      = cmd_l_reg;
        stat.mode_sel = mode_l_reg;
        stat.power_on = power_l_reg;
        stat.light_on = light_reg;
        stat.mode     = mode_reg;
        stat.tick_hit = tick_inc >= period;
        stat.div_busy = div_busy || div_start;
        stat.ch_last  = idx_reg == 2'd2;
        stat.out_free = !ovalid_reg || out_ready;
    end

    assign out_valid  = ovalid_reg;
    assign red_duty   = od_r_reg;
    assign green_duty = od_g_reg;
    assign blue_duty  = od_b_reg;
endmodule

/* design/rgbled_ctrl.sv */
// Controller: sequences the datapath for each command beat.
// Depends on rgbled_pkg; drives rgbled_dp through its command struct.
module rgbled_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rgbled_pkg::dp_stat_t  stat,
    output rgbled_pkg::dp_cmd_t   cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_SET, S_APPLY, S_RUN, S_PULSE,
        S_MUL_C, S_DIV_C, S_WAIT_C, S_MUL_X, S_DIV_X, S_WAIT_X,
        S_MUL_CH, S_DIV_CH, S_WAIT_CH,
        S_LP_HUE, S_LP_HUE_W, S_LP_SAT, S_LP_SAT_W, S_LP_VAL, S_LP_VAL_W,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        SEL_STORED, SEL_RES, SEL_STORE_RES, SEL_ZERO
    } emit_sel_t;

    state_t             state_reg;
    emit_sel_t          sel_reg;
    logic               store_res_reg;
    logic               emit_after_reg;
    logic               ready_reg;
    rgbled_pkg::dp_op_t op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sel_reg        <= SEL_STORED;
            store_res_reg  <= 1'b0;
            emit_after_reg <= 1'b0;
            ready_reg      <= 1'b1;
            op_reg         <= rgbled_pkg::OP_NONE;
        end
        else
        begin
            op_reg <= rgbled_pkg::OP_NONE;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && ready_reg)
                    begin
                        ready_reg <= 1'b0;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    ready_reg <= 1'b1;
                    state_reg <= S_IDLE;
                    priority case (stat.cmd)
                        rgbled_pkg::CMD_SET_RGB:
                        begin
                            op_reg         <= rgbled_pkg::OP_SET_RGB;
                            emit_after_reg <= 1'b1;
                            ready_reg      <= 1'b0;
                            state_reg      <= S_LP_HUE;
                        end
                        rgbled_pkg::CMD_SET_HSV:
                        begin
                            op_reg        <= rgbled_pkg::OP_SET_HSV;
                            store_res_reg <= 1'b1;
                            ready_reg     <= 1'b0;
                            state_reg     <= S_MUL_C;
                        end
                        rgbled_pkg::CMD_SET_MODE:
                        begin
                            if (stat.mode_sel == rgbled_pkg::MODE_SOLID
                                || stat.mode_sel == rgbled_pkg::MODE_RUN
                                || stat.mode_sel == rgbled_pkg::MODE_PULSE)
                            begin
                                op_reg    <= rgbled_pkg::OP_SET_MODE;
                                ready_reg <= 1'b0;
                                state_reg <= S_SET;
                            end
                        end
                        rgbled_pkg::CMD_SET_POWER:
                        begin
                            op_reg    <= rgbled_pkg::OP_SET_POWER;
                            ready_reg <= 1'b0;
                            if (stat.power_on)
                                state_reg <= S_SET;
                            else
                            begin
                                sel_reg   <= SEL_ZERO;
                                state_reg <= S_EMIT;
                            end
                        end
                        rgbled_pkg::CMD_TICK:
                        begin
                            if (stat.light_on && (stat.mode == rgbled_pkg::MODE_RUN
                                || stat.mode == rgbled_pkg::MODE_PULSE))
                            begin
                                op_reg <= rgbled_pkg::OP_TICK;
                                if (stat.tick_hit)
                                begin
                                    ready_reg     <= 1'b0;
                                    store_res_reg <= 1'b0;
                                    state_reg     <= (stat.mode == rgbled_pkg::MODE_RUN)
                                                     ? S_RUN : S_PULSE;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_SET:
                    state_reg <= S_APPLY;
                S_APPLY:
                begin
                    ready_reg <= 1'b1;
                    state_reg <= S_IDLE;
                    if (stat.light_on)
                    begin
                        priority case (stat.mode)
                            rgbled_pkg::MODE_SOLID:
                            begin
                                ready_reg <= 1'b0;
                                sel_reg   <= SEL_STORED;
                                state_reg <= S_EMIT;
                            end
                            rgbled_pkg::MODE_RUN:
                                op_reg <= rgbled_pkg::OP_CLR_TICK_RUN;
                            default:
                            begin
                                op_reg         <= rgbled_pkg::OP_CLR_TICK;
                                emit_after_reg <= 1'b0;
                                ready_reg      <= 1'b0;
                                state_reg      <= S_LP_HUE;
                            end
                        endcase
                    end
                end
                S_RUN:
                begin
                    op_reg    <= rgbled_pkg::OP_RUN_STEP;
                    state_reg <= S_MUL_C;
                end
                S_PULSE:
                begin
                    op_reg    <= rgbled_pkg::OP_PULSE_STEP;
                    state_reg <= S_MUL_C;
                end
                S_MUL_C:
                begin
                    op_reg    <= rgbled_pkg::OP_MUL_VS;
                    state_reg <= S_DIV_C;
                end
                S_DIV_C:
                begin
                    op_reg    <= rgbled_pkg::OP_DIV_C;
                    state_reg <= S_WAIT_C;
                end
                S_WAIT_C:
                begin
                    if (!stat.div_busy)
                    begin
                        op_reg    <= rgbled_pkg::OP_TAKE_C;
                        state_reg <= S_MUL_X;
                    end
                end
                S_MUL_X:
                begin
                    op_reg    <= rgbled_pkg::OP_MUL_X;
                    state_reg <= S_DIV_X;
                end
                S_DIV_X:
                begin
                    op_reg    <= rgbled_pkg::OP_DIV_X;
                    state_reg <= S_WAIT_X;
                end
                S_WAIT_X:
                begin
                    if (!stat.div_busy)
                    begin
                        op_reg    <= rgbled_pkg::OP_TAKE_X;
                        state_reg <= S_MUL_CH;
                    end
                end
                S_MUL_CH:
                begin
                    op_reg    <= rgbled_pkg::OP_MUL_CH;
                    state_reg <= S_DIV_CH;
                end
                S_DIV_CH:
                begin
                    op_reg    <= rgbled_pkg::OP_DIV_CH;
                    state_reg <= S_WAIT_CH;
                end
                S_WAIT_CH:
                begin
                    if (!stat.div_busy)
                    begin
                        op_reg <= rgbled_pkg::OP_TAKE_CH;
                        if (stat.ch_last)
                        begin
                            sel_reg   <= store_res_reg ? SEL_STORE_RES : SEL_RES;
                            state_reg <= S_EMIT;
                        end
                        else
                            state_reg <= S_MUL_CH;
                    end
                end
                S_LP_HUE:
                begin
                    op_reg    <= rgbled_pkg::OP_DIV_HUE;
                    state_reg <= S_LP_HUE_W;
                end
                S_LP_HUE_W:
                begin
                    if (!stat.div_busy)
                    begin
                        op_reg    <= rgbled_pkg::OP_TAKE_HUE;
                        state_reg <= S_LP_SAT;
                    end
                end
                S_LP_SAT:
                begin
                    op_reg    <= rgbled_pkg::OP_DIV_SAT;
                    state_reg <= S_LP_SAT_W;
                end
                S_LP_SAT_W:
                begin
                    if (!stat.div_busy)
                    begin
                        op_reg    <= rgbled_pkg::OP_TAKE_SAT;
                        state_reg <= S_LP_VAL;
                    end
                end
                S_LP_VAL:
                begin
                    op_reg    <= rgbled_pkg::OP_DIV_VAL;
                    state_reg <= S_LP_VAL_W;
                end
                S_LP_VAL_W:
                begin
                    if (!stat.div_busy)
                    begin
                        op_reg <= rgbled_pkg::OP_TAKE_VAL;
                        if (emit_after_reg)
                        begin
                            sel_reg   <= SEL_STORED;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            ready_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (stat.out_free)
                    begin
                        unique case (sel_reg)
                            SEL_STORED:    op_reg <= rgbled_pkg::OP_EMIT_STORED;
                            SEL_RES:       op_reg <= rgbled_pkg::OP_EMIT_RES;
                            SEL_STORE_RES: op_reg <= rgbled_pkg::OP_STORE_EMIT_RES;
                            default:       op_reg <= rgbled_pkg::OP_EMIT_ZERO;
                        endcase
                        ready_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    ready_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready = ready_reg;
    assign cmd.op   = op_reg;
endmodule

/* design/rgb_led_effect_controller_unit.sv */
// Top level of the RGB LED effect controller: stream ports, APB registers, assertions.
// Depends on rgbled_pkg, rgbled_ctrl, rgbled_dp and the assertion macro header.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid/s_tready    s_tuser command, s_tdata colour/mode/power
//  m_*       out        m_tvalid/m_tready    m_tdata three PWM duties
//  APB       in         psel/penable/pready  run and pulse periods
//
// One beat at a time is processed. A set-rgb beat, or entering pulse mode by mode or
// power, takes its time from two passes of the serial divider. A set-hsv beat and an
// effect step are shorter, as constant divisions are reciprocal multiplications.
// A result waits in the output register while the next beat is taken; a beat with a
// result stalls until that register is free. Reset clears all effect state but sets
// the pulse falling flag.
`include "rgb_led_effect_controller_unit_macros.svh"
module rgb_led_effect_controller_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // red_in[7:0], green_in[15:8], blue_in[23:16], hue_in[36:24], sat_in[51:37],
    // val_in[66:52], mode_sel[68:67], power_on[69], zero[71:70]
    input  logic [71:0] s_tdata,
    // command[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // red_duty[9:0], green_duty[19:10], blue_duty[29:20], zero[31:30]
    output logic [31:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int TW = rgbled_pkg::PER_W;

    logic [TW-1:0] run_period_reg, pulse_period_reg;
    logic          cfg_wr, in_accept;
    logic [rgbled_pkg::DUTY_W-1:0] red_duty, green_duty, blue_duty;
    rgbled_pkg::dp_cmd_t  cmd;
    rgbled_pkg::dp_stat_t stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_period_reg   <= rgbled_pkg::RUN_PERIOD_RST;
            pulse_period_reg <= rgbled_pkg::PULSE_PERIOD_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                rgbled_pkg::REG_RUN_PERIOD:   run_period_reg   <= pwdata[TW-1:0];
                default:                      pulse_period_reg <= pwdata[TW-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            rgbled_pkg::REG_RUN_PERIOD: prdata = 32'(run_period_reg);
            default:                    prdata = 32'(pulse_period_reg);
        endcase
    end

    assign in_accept = s_tvalid && s_tready;

    rgbled_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rgbled_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_accept    (in_accept),
        .command      (s_tuser),
        .red_in       (s_tdata[7:0]),
        .green_in     (s_tdata[15:8]),
        .blue_in      (s_tdata[23:16]),
        .hue_in       (s_tdata[36:24]),
        .sat_in       (s_tdata[51:37]),
        .val_in       (s_tdata[66:52]),
        .mode_sel     (s_tdata[68:67]),
        .power_on     (s_tdata[69]),
        .run_period   (run_period_reg),
        .pulse_period (pulse_period_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .red_duty     (red_duty),
        .green_duty   (green_duty),
        .blue_duty    (blue_duty)
    );

    assign m_tdata = {2'b00, blue_duty, green_duty, red_duty};

    `RGBLED_ASSERT_NEXT(a_one_beat_at_a_time, in_accept, !s_tready)
    `RGBLED_ASSERT_SAME(a_divider_idle_when_ready, s_tready, !stat.div_busy)
    `RGBLED_ASSERT_SAME(a_duty_multiple_of_four, m_tvalid,
        m_tdata[1:0] == 2'b00 && m_tdata[11:10] == 2'b00 && m_tdata[21:20] == 2'b00)
endmodule
